### hw/rtl/ird_pkg.sv
// Shared types and constants for the indexed ring deque.
`timescale 1ns / 1ps
package ird_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned RESULT_W = 32;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET         = 3'd0,
    OP_PUT         = 3'd1,
    OP_ADD         = 3'd2,
    OP_REMOVE      = 3'd3,
    OP_REMOVE_LAST = 3'd4,
    OP_ROTATE      = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_WRAP
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_ROTATE
  } state_e;

endpackage

### hw/rtl/ird_cell.sv
// One storage cell of the deque row: holds one element and loads a new value, a neighbor's value or the wrap value.
`timescale 1ns / 1ps
module ird_cell
  import ird_pkg::*;
#(
  parameter int unsigned WIDTH = VALUE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  cell_op_e         op_i,
  input  logic [WIDTH-1:0] load_i,
  input  logic [WIDTH-1:0] left_i,
  input  logic [WIDTH-1:0] right_i,
  input  logic [WIDTH-1:0] wrap_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] data_q;
  logic [WIDTH-1:0] data_d;

  always_comb begin
    unique case (op_i)
      CELL_LOAD:  data_d = load_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      CELL_WRAP:  data_d = wrap_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

### hw/rtl/indexed_ring_deque_top.sv
// Top level of the indexed ring deque: control, cell row and result register.
//
// Usage: one request transaction on s_axis, one result transaction on m_axis.
//   s_axis_tuser carries the opcode (get, put, add, remove, remove last,
//   rotate); s_axis_tdata carries the position and the value to store.
//   m_axis_tdata returns the value and the element count after the request;
//   m_axis_tuser flags a refused request (value reads zero then).
// Elements sit in logical order in a row of cells, cell k holding element k.
//   Inserts and removes shift all affected cells by one position together.
// The result is registered and valid the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken, for every opcode except rotate.
//   A rotate by an effective amount of s (0..count-1) keeps s_axis_tready
//   low until the row has stepped left by s cells, one cell per cycle.
// Stall: a result not taken holds in the output register; a new request is
//   accepted in the same cycle as that result is taken.
// Reset: the deque is empty, no result is pending, ready rises at once.
`timescale 1ns / 1ps
module indexed_ring_deque_top
  import ird_pkg::*;
#(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] position, [37:6] item_value, [39:38] zero
  input  logic [39:0] s_axis_tdata_i,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] result_value, [36:32] count, [39:37] zero
  output logic [39:0] m_axis_tdata_o,
  // [0] error
  output logic        m_axis_tuser_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + POS_W + 1;

  state_e                  state_q, state_d;
  logic [CW-1:0]           len_q, len_d;
  logic [IW-1:0]           rot_q, rot_d;
  logic                    m_valid_q;
  logic [RESULT_W-1:0]     m_val_q;
  logic [COUNT_W-1:0]      m_cnt_q;
  logic                    m_err_q;

  logic                    s_accept;
  op_e                     opcode;
  logic [POS_W-1:0]        position;
  logic [ITEM_W-1:0]       item_value;
  logic [VALUE_WIDTH-1:0]  x_val;
  logic [VALUE_WIDTH+ITEM_W-1:0] x_ext;

  logic signed [SW-1:0]    pos_s, len_s, idx_s, sh_s;
  logic [CW-1:0]           len_m1, idx_u;
  logic [IW-1:0]           rd_idx;
  logic [VALUE_WIDTH-1:0]  rd_val;
  logic                    in_range, add_ok, rot_ok;

  logic [VALUE_WIDTH-1:0]  res_v;
  logic [VALUE_WIDTH+RESULT_W-1:0] res_ext;
  logic [CW+COUNT_W-1:0]   cnt_ext;
  logic                    res_err;

  cell_op_e                cell_op [CAPACITY];
  logic [VALUE_WIDTH-1:0]  cell_q  [CAPACITY];
  logic [VALUE_WIDTH-1:0]  left_w  [CAPACITY];
  logic [VALUE_WIDTH-1:0]  right_w [CAPACITY];

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign opcode     = op_e'(s_axis_tuser_i);
  assign position   = s_axis_tdata_i[POS_W-1:0];
  assign item_value = s_axis_tdata_i[POS_W+ITEM_W-1:POS_W];
  assign x_ext      = {{VALUE_WIDTH{1'b0}}, item_value};
  assign x_val      = x_ext[VALUE_WIDTH-1:0];

  assign pos_s  = {{(SW-POS_W){position[POS_W-1]}}, position};
  assign len_s  = {{(SW-CW){1'b0}}, len_q};
  assign len_m1 = len_q - CW'(1);

  assign in_range = (pos_s >= 0) && (pos_s < len_s);
  assign add_ok   = (len_q < CW'(CAPACITY)) && (pos_s >= -len_s) && (pos_s <= len_s + 1);
  assign rot_ok   = (pos_s >= -len_s) && (pos_s <= len_s);

  always_comb begin
    priority if (pos_s == 0) begin
      idx_s = len_s;
    end else if (pos_s < 0) begin
      idx_s = pos_s + len_s;
    end else begin
      idx_s = pos_s - SW'(1);
    end
  end
  assign idx_u = idx_s[CW-1:0];

  always_comb begin
    sh_s = (pos_s < 0) ? pos_s + len_s : pos_s;
    if (sh_s == len_s) begin
      sh_s = '0;
    end
  end

  assign rd_idx = (opcode == OP_REMOVE_LAST) ? len_m1[IW-1:0] : pos_s[IW-1:0];
  assign rd_val = cell_q[rd_idx];

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    rot_d   = rot_q;
    res_v   = '0;
    res_err = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      cell_op[k] = CELL_HOLD;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          unique case (opcode)
            OP_GET, OP_PUT: begin
              if (in_range) begin
                res_v = rd_val;
                if (opcode == OP_PUT) begin
                  for (int k = 0; k < CAPACITY; k++) begin
                    if (pos_s[IW-1:0] == IW'(k)) cell_op[k] = CELL_LOAD;
                  end
                end
              end else begin
                res_err = 1'b1;
              end
            end
            OP_ADD: begin
              if (add_ok) begin
                res_v = x_val;
                len_d = len_q + CW'(1);
                for (int k = 0; k < CAPACITY; k++) begin
                  if (CW'(k) > idx_u) begin
                    cell_op[k] = CELL_LEFT;
                  end else if (CW'(k) == idx_u) begin
                    cell_op[k] = CELL_LOAD;
                  end
                end
              end else begin
                res_err = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (in_range) begin
                res_v = rd_val;
                len_d = len_m1;
                for (int k = 0; k < CAPACITY; k++) begin
                  if (CW'(k) >= pos_s[CW-1:0]) cell_op[k] = CELL_RIGHT;
                end
              end else begin
                res_err = 1'b1;
              end
            end
            OP_REMOVE_LAST: begin
              if (len_q != '0) begin
                res_v = rd_val;
                len_d = len_m1;
              end else begin
                res_err = 1'b1;
              end
            end
            OP_ROTATE: begin
              if (!rot_ok) begin
                res_err = 1'b1;
              end else if (sh_s != '0) begin
                rot_d   = sh_s[IW-1:0];
                state_d = ST_ROTATE;
              end
            end
            default: begin
              res_err = 1'b1;
            end
          endcase
        end
      end
      ST_ROTATE: begin
        for (int k = 0; k < CAPACITY; k++) begin
          if (CW'(k) < len_m1) begin
            cell_op[k] = CELL_RIGHT;
          end else if (CW'(k) == len_m1) begin
            cell_op[k] = CELL_WRAP;
          end
        end
        rot_d = rot_q - IW'(1);
        if (rot_q == IW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_w[k] = cell_q[k];
    end else begin : g_left
      assign left_w[k] = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w[k] = cell_q[k];
    end else begin : g_right
      assign right_w[k] = cell_q[k+1];
    end

    ird_cell #(
      .WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[k]),
      .load_i  (x_val),
      .left_i  (left_w[k]),
      .right_i (right_w[k]),
      .wrap_i  (cell_q[0]),
      .q_o     (cell_q[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      rot_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      rot_q   <= rot_d;
      if (s_accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign res_ext = {{RESULT_W{1'b0}}, res_v};
  assign cnt_ext = {{COUNT_W{1'b0}}, len_d};

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      m_val_q <= res_ext[RESULT_W-1:0];
      m_cnt_q <= cnt_ext[COUNT_W-1:0];
      m_err_q <= res_err;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b000, m_cnt_q, m_val_q};
  assign m_axis_tuser_o  = m_err_q;

endmodule

### hw/rtl/ird_checker.sv
// Port-level checks for the indexed ring deque, bound to the top level.
`timescale 1ns / 1ps
module ird_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted request produced no result");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[31:0] == 32'd0)
    else $error("refused request returned a nonzero value");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("request accepted over a pending result");

endmodule

bind indexed_ring_deque_top ird_checker u_ird_checker (.*);
